// ----- src/tsm_pkg.sv -----
// ----------------------------------------------------------------------------
// tsm_pkg
// Shared widths, command codes and the queue entry type of the ternary
// segment matrix-vector block.
// ----------------------------------------------------------------------------
package tsm_pkg;

   // field widths
   localparam int CMD_W  = 2;
   localparam int COL_W  = 12;
   localparam int ACT_W  = 8;
   localparam int MASK_W = 16;
   localparam int SUM_W  = 21;
   localparam int IDX_W  = 4;
   localparam int CFG_W  = 5;

   // parameter defaults
   localparam int DEF_VECTOR_DEPTH = 4096;
   localparam int DEF_ROWS         = 16;

   // front to back queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // row count after reset
   localparam logic [CFG_W-1:0] ROW_COUNT_RESET = 5'd16;

   // item commands
   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD   = 2'd0,
      CMD_COLUMN = 2'd1,
      CMD_FINISH = 2'd2
   } cmd_type;

   // work handed from the front end to the back end
   typedef struct packed {
      logic                    is_finish;
      logic signed [ACT_W-1:0] act;
      logic                    group_end;
      logic [MASK_W-1:0]       plus_mask;
      logic [MASK_W-1:0]       minus_mask;
   } op_type;

endpackage

// ----- src/tsm_req_if.sv -----
// ----------------------------------------------------------------------------
// tsm_req_if
// Input item channel: valid, ready and one command item.
// ----------------------------------------------------------------------------
interface tsm_req_if;
   import tsm_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [CMD_W-1:0]        command;
   logic [COL_W-1:0]        column;
   logic signed [ACT_W-1:0] activation;
   logic                    group_end;
   logic [MASK_W-1:0]       plus_mask;
   logic [MASK_W-1:0]       minus_mask;

   modport source (
      output valid, command, column, activation, group_end, plus_mask, minus_mask,
      input  ready
   );

   modport sink (
      input  valid, command, column, activation, group_end, plus_mask, minus_mask,
      output ready
   );

endinterface

// ----- src/tsm_rsp_if.sv -----
// ----------------------------------------------------------------------------
// tsm_rsp_if
// Result item channel: valid, ready and one row result.
// ----------------------------------------------------------------------------
interface tsm_rsp_if;
   import tsm_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [SUM_W-1:0] row_sum;
   logic [IDX_W-1:0]        row_index;
   logic                    last_row;

   modport source (
      output valid, row_sum, row_index, last_row,
      input  ready
   );

   modport sink (
      input  valid, row_sum, row_index, last_row,
      output ready
   );

endinterface

// ----- src/tsm_ram.sv -----
// ----------------------------------------------------------------------------
// tsm_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module tsm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/tsm_queue.sv -----
// ----------------------------------------------------------------------------
// tsm_queue
// Small FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module tsm_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  logic [WIDTH-1:0]             push_data,
   input  logic                         pop,
   output logic                         pop_valid,
   output logic [WIDTH-1:0]             pop_data,
   output logic [$clog2(DEPTH+1)-1:0]   count
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_valid = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];
   assign count     = count_ff;

`ifndef SYNTHESIS
   // the front end reserves room, so a push never meets a full queue
   assert property (@(posedge clock) disable iff (reset)
      push |-> (32'(count_ff) < DEPTH))
      else $error("tsm_queue: push while full");

   // the back end only takes an entry that is there
   assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("tsm_queue: pop while empty");

   // fill count moves only with traffic
   assert property (@(posedge clock) disable iff (reset)
      (!push && !pop) |=> $stable(count_ff))
      else $error("tsm_queue: count changed without traffic");
`endif

endmodule

// ----- src/tsm_front.sv -----
// ----------------------------------------------------------------------------
// tsm_front
// Accepts items, writes loads into the vector store, reads the activation of
// column items and hands column and finish work to the queue.
// ----------------------------------------------------------------------------
module tsm_front #(
   parameter int VECTOR_DEPTH = tsm_pkg::DEF_VECTOR_DEPTH
) (
   input  logic                         clock,
   input  logic                         reset,
   tsm_req_if.sink                      req,
   input  logic [tsm_pkg::QCNT_W-1:0]   q_count,
   output logic                         q_push,
   output tsm_pkg::op_type              q_push_data
);
   import tsm_pkg::*;

   localparam int AW = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;

   logic [31:0]        col_wide;
   logic [AW-1:0]      addr;
   logic               in_range;
   logic               accept;
   logic               ram_we;
   logic [ACT_W-1:0]   ram_rd_data;
   logic               s1_valid_ff, s1_valid_in;
   logic               s1_finish_ff, s1_finish_in;
   logic               s1_in_range_ff;
   logic               s1_group_end_ff;
   logic [MASK_W-1:0]  s1_plus_ff;
   logic [MASK_W-1:0]  s1_minus_ff;

   // store address and range check
   assign col_wide = 32'(req.column);
   assign addr     = col_wide[AW-1:0];
   assign in_range = (col_wide < 32'(VECTOR_DEPTH));

   // one queue slot stays reserved for the item in the read stage
   assign req.ready = ((32'(q_count) + 32'(s1_valid_ff)) < 32'(QUEUE_DEPTH));
   assign accept    = req.valid && req.ready;

   // command decode
   always_comb begin
      ram_we       = 1'b0;
      s1_valid_in  = 1'b0;
      s1_finish_in = 1'b0;
      unique case (req.command)
         CMD_LOAD: begin
            ram_we = accept && in_range;
         end
         CMD_COLUMN: begin
            s1_valid_in = accept;
         end
         CMD_FINISH: begin
            s1_valid_in  = accept;
            s1_finish_in = 1'b1;
         end
         default: begin
            s1_valid_in = 1'b0;
         end
      endcase
   end

   tsm_ram #(
      .WIDTH (ACT_W),
      .DEPTH (VECTOR_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (addr),
      .wr_data (req.activation),
      .rd_addr (addr),
      .rd_data (ram_rd_data)
   );

   // read stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // read stage payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_finish_ff    <= s1_finish_in;
         s1_in_range_ff  <= in_range;
         s1_group_end_ff <= req.group_end;
         s1_plus_ff      <= req.plus_mask;
         s1_minus_ff     <= req.minus_mask;
      end
   end

   // queue entry, out of range columns add zero
   always_comb begin
      q_push_data.is_finish  = s1_finish_ff;
      q_push_data.act        = s1_in_range_ff ? $signed(ram_rd_data) : '0;
      q_push_data.group_end  = s1_group_end_ff;
      q_push_data.plus_mask  = s1_plus_ff;
      q_push_data.minus_mask = s1_minus_ff;
   end

   assign q_push = s1_valid_ff;

endmodule

// ----- src/tsm_back.sv -----
// ----------------------------------------------------------------------------
// tsm_back
// Keeps the group sum and the row sums, applies closed groups to the rows and
// emits the rows one per cycle on a finish while the result channel takes them.
// ----------------------------------------------------------------------------
module tsm_back #(
   parameter int ROWS = tsm_pkg::DEF_ROWS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_valid,
   input  tsm_pkg::op_type             q_data,
   output logic                        q_pop,
   input  logic                        csr_wr_en,
   input  logic [tsm_pkg::CFG_W-1:0]   csr_wr_data,
   tsm_rsp_if.source                   rsp
);
   import tsm_pkg::*;

   localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;

   logic [CFG_W-1:0]        row_count_ff, row_count_in;
   logic [CFG_W-1:0]        eff_rows;
   logic [CFG_W-1:0]        last_idx;
   logic signed [SUM_W-1:0] row_ff [ROWS];
   logic signed [SUM_W-1:0] row_in [ROWS];
   logic signed [SUM_W-1:0] group_ff, group_in;
   logic signed [SUM_W-1:0] gs_sum;
   logic [RW-1:0]           idx_ff, idx_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [SUM_W-1:0] rsp_sum_ff, rsp_sum_in;
   logic [IDX_W-1:0]        rsp_idx_ff, rsp_idx_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic                    out_free;
   logic                    emit_last;

   // row count register
   assign row_count_in = csr_wr_en ? csr_wr_data : row_count_ff;

   // clamp row count to one .. ROWS
   always_comb begin
      if (row_count_ff == '0) begin
         eff_rows = CFG_W'(1);
      end else if (row_count_ff > CFG_W'(ROWS)) begin
         eff_rows = CFG_W'(ROWS);
      end else begin
         eff_rows = row_count_ff;
      end
   end

   assign last_idx  = eff_rows - 1'b1;
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign gs_sum    = group_ff + SUM_W'(q_data.act);
   assign emit_last = (CFG_W'(idx_ff) == last_idx);

   // column and finish processing
   always_comb begin
      row_in       = row_ff;
      group_in     = group_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_sum_in   = rsp_sum_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_last_in  = rsp_last_ff;
      q_pop        = 1'b0;
      if (q_valid && !q_data.is_finish) begin
         q_pop = 1'b1;
         if (q_data.group_end) begin
            // closed group goes to every selected active row
            for (int r = 0; r < ROWS; r++) begin
               if (CFG_W'(r) < eff_rows) begin
                  if (q_data.plus_mask[r] && !q_data.minus_mask[r]) begin
                     row_in[r] = row_ff[r] + gs_sum;
                  end else if (q_data.minus_mask[r] && !q_data.plus_mask[r]) begin
                     row_in[r] = row_ff[r] - gs_sum;
                  end
               end
            end
            group_in = '0;
         end else begin
            group_in = gs_sum;
         end
      end else if (q_valid && q_data.is_finish && out_free) begin
         // one row into the output register per cycle while it is free
         rsp_valid_in = 1'b1;
         rsp_sum_in   = row_ff[idx_ff];
         rsp_idx_in   = IDX_W'(idx_ff);
         rsp_last_in  = emit_last;
         if (emit_last) begin
            q_pop    = 1'b1;
            idx_in   = '0;
            group_in = '0;
            for (int r = 0; r < ROWS; r++) begin
               row_in[r] = '0;
            end
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= ROW_COUNT_RESET;
         row_ff       <= '{default: '0};
         group_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_count_ff <= row_count_in;
         row_ff       <= row_in;
         group_ff     <= group_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output register payload
   always_ff @(posedge clock) begin
      rsp_sum_ff  <= rsp_sum_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.row_sum   = rsp_sum_ff;
   assign rsp.row_index = rsp_idx_ff;
   assign rsp.last_row  = rsp_last_ff;

endmodule

// ----- src/ternary_segment_matvec.sv -----
// ----------------------------------------------------------------------------
// ternary_segment_matvec
// Ternary-weight matrix-vector block with segment reduction: int8 activation
// store, group sum and per-row signed accumulators.
//
//   channel   dir   handshake          payload
//   req       in    valid / ready      command, column, activation,
//                                      group_end, plus_mask, minus_mask
//   rsp       out   valid / ready      row_sum, row_index, last_row
//   csr       in    csr_wr_en          csr_wr_data (row_count)
//
// Load and column items are taken one per cycle while the queue has room; a
// column is registered at the store read and then waits in the queue until
// the back end takes it from the queue head and adds it to the accumulators.
// A finish item occupies the back end until every active row is emitted, one
// row result per cycle out of the output register while rsp is ready, and the
// front keeps accepting until the four-entry queue fills.
// Reset is synchronous; row sums and group sum clear at once, the vector
// store holds no reset value and needs no clearing pass.
// A stalled result holds a finish in the back end; the queue lets the front run ahead.
// ----------------------------------------------------------------------------
module ternary_segment_matvec #(
   parameter int VECTOR_DEPTH = tsm_pkg::DEF_VECTOR_DEPTH,
   parameter int ROWS         = tsm_pkg::DEF_ROWS
) (
   input  logic                        clock,
   input  logic                        reset,
   tsm_req_if.sink                     req,
   tsm_rsp_if.source                   rsp,
   input  logic                        csr_wr_en,
   input  logic [tsm_pkg::CFG_W-1:0]   csr_wr_data
);
   import tsm_pkg::*;

   logic              q_push;
   op_type            q_push_data;
   logic              q_pop;
   logic              q_valid;
   op_type            q_data;
   logic [QCNT_W-1:0] q_count;

   // item intake and vector store
   tsm_front #(
      .VECTOR_DEPTH (VECTOR_DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .q_count     (q_count),
      .q_push      (q_push),
      .q_push_data (q_push_data)
   );

   // decoupling queue
   tsm_queue #(
      .WIDTH ($bits(op_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_data  (q_data),
      .count     (q_count)
   );

   // accumulation and row emission
   tsm_back #(
      .ROWS (ROWS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_data      (q_data),
      .q_pop       (q_pop),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp         (rsp)
   );

endmodule
